/* rtl/tvfp_pkg.sv */
// ----------------------------------------------------------------------------
// tvfp_pkg
// Shared types and constants of the tag=value field parser.
// ----------------------------------------------------------------------------
package tvfp_pkg;

  localparam logic [7:0] SOH_BYTE    = 8'h01;
  localparam logic [7:0] EQUALS_CHAR = 8'h3D;
  localparam logic [7:0] POINT_CHAR  = 8'h2E;
  localparam logic [7:0] ZERO_CHAR   = 8'h30;
  localparam logic [7:0] NINE_CHAR   = 8'h39;

  localparam logic [7:0] MAX_LEN_RESET = 8'd64;

  localparam int OFFSET_W    = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_POINT,
    CLS_EQUALS,
    CLS_SOH,
    CLS_OTHER
  } byte_class_t;

  typedef struct packed {
    byte_class_t           cls;
    logic [7:0]            data;
    logic [OFFSET_W-1:0]   offset;
  } queue_entry_t;

  typedef struct packed {
    logic [19:0]         tag_number;
    logic [30:0]         value_mantissa;
    logic [4:0]          decimal_count;
    logic                has_point;
    logic [7:0]          last_char;
    logic [7:0]          value_length;
    logic [OFFSET_W-1:0] tag_offset;
    logic                missing_equals;
    logic                non_digit;
    logic                overflow;
    logic                too_long;
  } field_result_t;

endpackage

/* rtl/tvfp_front.sv */
// ----------------------------------------------------------------------------
// tvfp_front
// Accepts message bytes, classifies them and stamps field offsets.
// ----------------------------------------------------------------------------
module tvfp_front
  import tvfp_pkg::*;
#(
  parameter int POSITION_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_byte,
  output logic         push_valid,
  input  logic         push_ready,
  output queue_entry_t push_entry
);

  logic [POSITION_WIDTH-1:0] position;
  logic [POSITION_WIDTH-1:0] field_start;
  logic [31:0]               start_wide;
  logic                      transfer;
  byte_class_t               cls;

  always_comb begin
    if (in_byte == SOH_BYTE) begin
      cls = CLS_SOH;
    end else if (in_byte == EQUALS_CHAR) begin
      cls = CLS_EQUALS;
    end else if (in_byte == POINT_CHAR) begin
      cls = CLS_POINT;
    end else if (in_byte >= ZERO_CHAR && in_byte <= NINE_CHAR) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign start_wide = 32'(field_start);
  assign transfer   = in_valid && push_ready;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  assign push_entry.cls    = cls;
  assign push_entry.data   = in_byte;
  assign push_entry.offset = start_wide[OFFSET_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      field_start <= '0;
    end else if (transfer) begin
      position <= position + 1'b1;
      // next field begins right after the SOH
      if (cls == CLS_SOH) begin
        field_start <= position + 1'b1;
      end
    end
  end

endmodule

/* rtl/tvfp_queue.sv */
// ----------------------------------------------------------------------------
// tvfp_queue
// Small FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module tvfp_queue
  import tvfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  queue_entry_t push_entry,
  output logic         pop_valid,
  input  logic         pop_ready,
  output queue_entry_t pop_entry
);

  queue_entry_t        slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push;
  logic                pop;

  assign push_ready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/tvfp_back.sv */
// ----------------------------------------------------------------------------
// tvfp_back
// Field accumulators and result register.
// ----------------------------------------------------------------------------
module tvfp_back
  import tvfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    max_len,
  input  logic          q_valid,
  output logic          q_ready,
  input  queue_entry_t  q_entry,
  output logic          out_valid,
  input  logic          out_ready,
  output field_result_t result
);

  localparam int ERR_NONDIGIT = 0;
  localparam int ERR_OVERFLOW = 1;
  localparam int ERR_TOOLONG  = 2;

  localparam logic [19:0] TAG_MAX  = 20'hFFFFF;
  localparam logic [30:0] MANT_MAX = 31'h7FFFFFFF;
  localparam logic [4:0]  DEC_MAX  = 5'd31;
  localparam logic [7:0]  LEN_MAX  = 8'd255;

  function automatic logic [34:0] mul10_add(input logic [30:0] acc, input logic [3:0] d);
    logic [34:0] a;
    a = {4'b0, acc};
    return (a << 3) + (a << 1) + {31'b0, d};
  endfunction

  logic          in_value;
  logic [19:0]   tag_acc;
  logic [30:0]   mant_acc;
  logic [4:0]    dec_acc;
  logic          point_seen;
  logic [7:0]    last_byte;
  logic [7:0]    len_cnt;
  logic [2:0]    err_flags;

  logic          in_value_next;
  logic [19:0]   tag_acc_next;
  logic [30:0]   mant_acc_next;
  logic [4:0]    dec_acc_next;
  logic          point_seen_next;
  logic [7:0]    last_byte_next;
  logic [7:0]    len_cnt_next;
  logic [2:0]    err_flags_next;
  logic          out_valid_next;
  field_result_t result_next;

  logic          pop;
  logic          is_soh;
  logic [3:0]    digit;
  logic [34:0]   tag_sum;
  logic [34:0]   mant_sum;

  assign is_soh  = (q_entry.cls == CLS_SOH);
  // an SOH needs the result register free or draining this cycle
  assign pop     = q_valid && (!is_soh || !out_valid || out_ready);
  assign q_ready = pop;
  assign digit   = q_entry.data[3:0];
  assign tag_sum  = mul10_add({11'b0, tag_acc}, digit);
  assign mant_sum = mul10_add(mant_acc, digit);

  always_comb begin
    in_value_next   = in_value;
    tag_acc_next    = tag_acc;
    mant_acc_next   = mant_acc;
    dec_acc_next    = dec_acc;
    point_seen_next = point_seen;
    last_byte_next  = last_byte;
    len_cnt_next    = len_cnt;
    err_flags_next  = err_flags;
    result_next     = result;

    if (pop) begin
      if (is_soh) begin
        result_next.tag_number = tag_acc;
        result_next.tag_offset = q_entry.offset;
        result_next.non_digit  = err_flags[ERR_NONDIGIT];
        result_next.overflow   = err_flags[ERR_OVERFLOW];
        if (in_value) begin
          result_next.value_mantissa = mant_acc;
          result_next.decimal_count  = dec_acc;
          result_next.has_point      = point_seen;
          result_next.last_char      = last_byte;
          result_next.value_length   = (len_cnt == LEN_MAX) ? LEN_MAX : len_cnt + 8'd1;
          result_next.missing_equals = 1'b0;
          // length + SOH > max  <=>  length >= max
          result_next.too_long       = err_flags[ERR_TOOLONG] || (len_cnt >= max_len);
        end else begin
          result_next.value_mantissa = '0;
          result_next.decimal_count  = '0;
          result_next.has_point      = 1'b0;
          result_next.last_char      = '0;
          result_next.value_length   = '0;
          result_next.missing_equals = 1'b1;
          result_next.too_long       = 1'b0;
        end
        in_value_next   = 1'b0;
        tag_acc_next    = '0;
        mant_acc_next   = '0;
        dec_acc_next    = '0;
        point_seen_next = 1'b0;
        last_byte_next  = '0;
        len_cnt_next    = '0;
        err_flags_next  = '0;
      end else if (!in_value) begin
        case (q_entry.cls)
          CLS_EQUALS: in_value_next = 1'b1;
          CLS_DIGIT: begin
            if (tag_sum > {15'b0, TAG_MAX}) begin
              tag_acc_next = TAG_MAX;
              err_flags_next[ERR_OVERFLOW] = 1'b1;
            end else begin
              tag_acc_next = tag_sum[19:0];
            end
          end
          default: err_flags_next[ERR_NONDIGIT] = 1'b1;
        endcase
      end else begin
        last_byte_next = q_entry.data;
        if (len_cnt != LEN_MAX) begin
          len_cnt_next = len_cnt + 8'd1;
        end
        if (len_cnt_next >= max_len) begin
          err_flags_next[ERR_TOOLONG] = 1'b1;
        end
        if (q_entry.cls == CLS_POINT && !point_seen) begin
          point_seen_next = 1'b1;
        end else if (q_entry.cls == CLS_DIGIT) begin
          if (mant_sum > {4'b0, MANT_MAX}) begin
            mant_acc_next = MANT_MAX;
            err_flags_next[ERR_OVERFLOW] = 1'b1;
          end else begin
            mant_acc_next = mant_sum[30:0];
          end
          if (point_seen) begin
            if (dec_acc != DEC_MAX) begin
              dec_acc_next = dec_acc + 5'd1;
            end else begin
              err_flags_next[ERR_OVERFLOW] = 1'b1;
            end
          end
        end else begin
          err_flags_next[ERR_NONDIGIT] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (pop && is_soh) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value   <= 1'b0;
      tag_acc    <= '0;
      mant_acc   <= '0;
      dec_acc    <= '0;
      point_seen <= 1'b0;
      last_byte  <= '0;
      len_cnt    <= '0;
      err_flags  <= '0;
      out_valid  <= 1'b0;
    end else begin
      in_value   <= in_value_next;
      tag_acc    <= tag_acc_next;
      mant_acc   <= mant_acc_next;
      dec_acc    <= dec_acc_next;
      point_seen <= point_seen_next;
      last_byte  <= last_byte_next;
      len_cnt    <= len_cnt_next;
      err_flags  <= err_flags_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_missing_eq_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.missing_equals |->
      result.value_length == 8'd0 && !result.too_long && !result.has_point)
    else $error("missing '=' result carries value data");

  a_value_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.missing_equals |-> result.value_length != 8'd0)
    else $error("value result with zero length");

  a_decimals_need_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.decimal_count != 5'd0 |-> result.has_point)
    else $error("decimal places without a point");

  a_no_soh_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(result))
    else $error("held result overwritten");

endmodule

/* rtl/tag_value_field_parser_unit.sv */
// ----------------------------------------------------------------------------
// tag_value_field_parser_unit
// Streaming parser for tag=value<SOH> message fields.
// ----------------------------------------------------------------------------
// One message byte is taken per cycle while the queue has room. A byte transfer
// lands in a four-entry queue; the back end retires one queue entry per cycle,
// unless an SOH waits on a held result, through its accumulators (multiply-by-ten
// and add, saturating). Only an SOH needs the result register, so a byte stalls
// only when an SOH meets a result not yet taken and the queue has filled. The SOH
// passes through the queue, then out_valid is registered in the back end. The
// max value length register may be written at any time the parser is idle;
// cfg_ready is always high.
module tag_value_field_parser_unit
  import tvfp_pkg::*;
#(
  parameter int POSITION_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] tag_number,
  output logic [30:0] value_mantissa,
  output logic [4:0]  decimal_count,
  output logic        has_point,
  output logic [7:0]  last_char,
  output logic [7:0]  value_length,
  output logic [15:0] tag_offset,
  output logic        missing_equals,
  output logic        non_digit,
  output logic        overflow,
  output logic        too_long
);

  logic          max_len;
  logic [7:0]    max_value_length;
  logic          push_valid;
  logic          push_ready;
  queue_entry_t  push_entry;
  logic          q_valid;
  logic          q_ready;
  queue_entry_t  q_entry;
  field_result_t result;

  assign cfg_ready = 1'b1;
  assign max_len   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value_length <= MAX_LEN_RESET;
    end else if (max_len) begin
      max_value_length <= cfg_data;
    end
  end

  tvfp_front #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  tvfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (q_entry)
  );

  tvfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .max_len   (max_value_length),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign tag_number     = result.tag_number;
  assign value_mantissa = result.value_mantissa;
  assign decimal_count  = result.decimal_count;
  assign has_point      = result.has_point;
  assign last_char      = result.last_char;
  assign value_length   = result.value_length;
  assign tag_offset     = result.tag_offset;
  assign missing_equals = result.missing_equals;
  assign non_digit      = result.non_digit;
  assign overflow       = result.overflow;
  assign too_long       = result.too_long;

endmodule

/* verif/tb_tag_value_field_parser_unit.sv */
// ----------------------------------------------------------------------------
// tb_tag_value_field_parser_unit
// Self-checking bench for the tag=value<SOH> field parser. A byte-level
// predictor tracks tag, mantissa, decimals, length and error flags, queues
// one expected field per SOH transfer, and a monitor compares every result
// transfer field by field. Runs directed field forms, saturation and length
// limit tests, plus random fields under varied throttling.
// ----------------------------------------------------------------------------
module tb_tag_value_field_parser_unit;
  import tvfp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [19:0] tag_number;
  logic [30:0] value_mantissa;
  logic [4:0]  decimal_count;
  logic        has_point;
  logic [7:0]  last_char;
  logic [7:0]  value_length;
  logic [15:0] tag_offset;
  logic        missing_equals;
  logic        non_digit;
  logic        overflow;
  logic        too_long;

  tag_value_field_parser_unit #(.POSITION_WIDTH(16)) DUT (.*);

  initial forever #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tag_value_field_parser_unit verification failed");
    $finish;
  end

  // Throttling, in percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int bytes_sent = 0;

  // Field parser prediction state
  field_result_t expected_fields[$];
  logic        in_value;
  logic [19:0] tag_acc;
  logic [30:0] mant_acc;
  logic [4:0]  dec_acc;
  logic        point_seen;
  logic [7:0]  last_val;
  logic [7:0]  len_cnt;
  logic [7:0]  max_len;
  logic [15:0] byte_pos;
  logic [15:0] field_pos;
  logic        err_digit;
  logic        err_sat;
  logic        err_long;

  function automatic bit is_digit(logic [7:0] ch);
    return ch >= ZERO_CHAR && ch <= NINE_CHAR;
  endfunction

  // acc*10 + digit, clamped to limit; clamping raises the overflow flag
  function automatic logic [31:0] shift_in_digit(logic [31:0] acc, logic [7:0] ch,
                                                 logic [31:0] limit);
    logic [35:0] sum;
    sum = acc * 36'd10 + (ch - ZERO_CHAR);
    if (sum > limit) begin
      err_sat = 1'b1;
      return limit;
    end
    return sum[31:0];
  endfunction

  function automatic void clear_field();
    in_value   = 1'b0;
    tag_acc    = '0;
    mant_acc   = '0;
    dec_acc    = '0;
    point_seen = 1'b0;
    last_val   = '0;
    len_cnt    = '0;
    err_digit  = 1'b0;
    err_sat    = 1'b0;
    err_long   = 1'b0;
  endfunction

  function automatic void parse_byte(logic [7:0] ch);
    field_result_t r;
    logic [8:0]    total;
    logic [31:0]   acc_next;
    if (ch == SOH_BYTE) begin
      r = '0;
      r.tag_number = tag_acc;
      r.tag_offset = field_pos;
      r.non_digit  = err_digit;
      r.overflow   = err_sat;
      if (in_value) begin
        total = {1'b0, len_cnt} + 9'd1;
        if (total > {1'b0, max_len}) err_long = 1'b1;
        r.value_mantissa = mant_acc;
        r.decimal_count  = dec_acc;
        r.has_point      = point_seen;
        r.last_char      = last_val;
        r.value_length   = total[8] ? 8'hFF : total[7:0];
        r.too_long       = err_long;
      end else begin
        r.missing_equals = 1'b1;
      end
      expected_fields.push_back(r);
      clear_field();
      field_pos = byte_pos + 16'd1;
    end else if (!in_value) begin
      if (ch == EQUALS_CHAR) begin
        in_value = 1'b1;
      end else if (is_digit(ch)) begin
        acc_next = shift_in_digit({12'd0, tag_acc}, ch, 32'h000F_FFFF);
        tag_acc  = acc_next[19:0];
      end else begin
        err_digit = 1'b1;
      end
    end else begin
      last_val = ch;
      if (len_cnt != 8'hFF) len_cnt = len_cnt + 8'd1;
      if ({1'b0, len_cnt} + 9'd1 > {1'b0, max_len}) err_long = 1'b1;
      if (ch == POINT_CHAR && !point_seen) begin
        point_seen = 1'b1;
      end else if (is_digit(ch)) begin
        acc_next = shift_in_digit({1'b0, mant_acc}, ch, 32'h7FFF_FFFF);
        mant_acc = acc_next[30:0];
        if (point_seen) begin
          if (dec_acc != 5'd31) dec_acc = dec_acc + 5'd1;
          else err_sat = 1'b1;
        end
      end else begin
        err_digit = 1'b1;
      end
    end
    byte_pos = byte_pos + 16'd1;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  // Result monitor and receiver throttle
  always @(posedge clk) begin
    field_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_fields.size() == 0) begin
          $display("%0t: result transfer with none pending, tag %0d", $time, tag_number);
          errors++;
        end else begin
          want = expected_fields.pop_front();
          compare_field("tag_number", 32'(want.tag_number), 32'(tag_number));
          compare_field("value_mantissa", 32'(want.value_mantissa), 32'(value_mantissa));
          compare_field("decimal_count", 32'(want.decimal_count), 32'(decimal_count));
          compare_field("has_point", 32'(want.has_point), 32'(has_point));
          compare_field("last_char", 32'(want.last_char), 32'(last_char));
          compare_field("value_length", 32'(want.value_length), 32'(value_length));
          compare_field("tag_offset", 32'(want.tag_offset), 32'(tag_offset));
          compare_field("missing_equals", 32'(want.missing_equals), 32'(missing_equals));
          compare_field("non_digit", 32'(want.non_digit), 32'(non_digit));
          compare_field("overflow", 32'(want.overflow), 32'(overflow));
          compare_field("too_long", 32'(want.too_long), 32'(too_long));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Returns at the edge of the transfer; valid stays up for the next call.
  task automatic send_byte(logic [7:0] ch);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= ch;
    do @(posedge clk); while (!in_ready);
    parse_byte(ch);
    bytes_sent++;
  endtask

  task automatic send_field(string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i]);
    send_byte(SOH_BYTE);
  endtask

  // Hold off input until every pending field has come out, then let the
  // byte queue empty too.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_length(logic [7:0] len);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_len = len;
  endtask

  task automatic test_field_forms();
    send_field("35=D");
    send_field("9=");
    send_field("44=0.5");
    send_field("12");
    send_field("");
    send_field("1a=.=.7");
  endtask

  task automatic test_saturation();
    send_field("1048575=2147483647");
    send_field("9999999=99999999999");
    send_field("1=0.00000000000000000000000000000000001");
  endtask

  task automatic test_length_limit();
    write_max_length(8'd1);
    send_field("1=");
    send_field("1=5");
    write_max_length(8'd0);
    send_field("2=");
    write_max_length(8'd12);
    // 11 value bytes plus SOH lands exactly on the limit
    send_field("4=77777777777");
    write_max_length(8'd255);
    // every byte value except SOH, long enough to saturate the length
    send_byte("3");
    send_byte(EQUALS_CHAR);
    for (int i = 0; i < 256; i++) send_byte(i[7:0] == SOH_BYTE ? 8'h02 : i[7:0]);
    send_byte(SOH_BYTE);
  endtask

  task automatic test_random_fields(int count);
    logic [7:0] seq[$];
    int start, kind, n, dot;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      seq.delete();
      kind = $urandom_range(0, 9);
      n = (kind == 5) ? 8 : $urandom_range(1, 4);
      repeat (n) seq.push_back(ZERO_CHAR + 8'($urandom_range(0, 9)));
      case (kind)
        6: begin
          seq.push_back(EQUALS_CHAR);
          seq.push_back(8'($urandom_range(2, 255)));
        end
        7: begin
          repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom_range(0, 255)));
        end
        8: begin
          if ($urandom_range(1)) seq.push_back(8'($urandom_range(2, 255)));
        end
        default: begin
          seq.push_back(EQUALS_CHAR);
          n = (kind == 9) ? $urandom_range(16, 40) : $urandom_range(0, 12);
          dot = $urandom_range(0, n + 2);
          for (int i = 0; i < n; i++) begin
            if (i == dot) seq.push_back(POINT_CHAR);
            else seq.push_back(ZERO_CHAR + 8'($urandom_range(0, 9)));
          end
        end
      endcase
      seq.push_back(SOH_BYTE);
      foreach (seq[i]) send_byte(seq[i]);
    end
  endtask

  initial begin
    clear_field();
    max_len   = MAX_LEN_RESET;
    byte_pos  = '0;
    field_pos = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 27;
    recv_idle_pct = 81;
    test_field_forms();
    test_saturation();
    test_length_limit();
    write_max_length(8'($urandom_range(4, 20)));
    test_random_fields(50);

    send_idle_pct = 81;
    recv_idle_pct = 27;
    write_max_length(8'd255);
    test_random_fields(35);
    write_max_length(8'($urandom_range(1, 12)));
    test_random_fields(35);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_max_length(MAX_LEN_RESET);
    test_random_fields(45);

    drain();
    if (errors == 0) begin
      $display("tag_value_field_parser_unit verification clean");
    end else begin
      $display("tag_value_field_parser_unit verification failed");
    end
    $finish;
  end

endmodule
